[hdl/sorted_key_set_with_ready_scan_core_assert.svh]
// Assertion macros shared by the checker of the sorted key set core.
`ifndef SORTED_KEY_SET_WITH_READY_SCAN_CORE_ASSERT_SVH
`define SORTED_KEY_SET_WITH_READY_SCAN_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SKS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SKS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/sks_pkg.sv]
// Shared types and codes of the sorted key set core.
`timescale 1ns / 1ps

package sks_pkg;

   localparam int CMD_W  = 3;
   localparam int ST_W   = 3;
   localparam int FLAG_W = 16;

   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_READY = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SCAN      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
   localparam logic [ST_W-1:0] ST_INVALID  = 3'd2;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

   // Control token that walks the cell row with a request.
   typedef struct packed {
      logic             active;    // token present at this cell
      logic [CMD_W-1:0] cmd;
      logic             use_mask;
      logic             full;      // set held CAPACITY keys at request start
      logic             resolved;  // status fixed, cells take no action
      logic [ST_W-1:0]  status;
      logic             carry;     // displaced entry travels with the token
      logic             placed;    // insert key already written
      logic             hit;       // query, set or scan matched a cell
   } ctl_type;

endpackage

[hdl/sks_cell.sv]
// One cell of the row: a key slot, its ready flags and a token stage.
`timescale 1ns / 1ps

module sks_cell #(
   parameter int KEY_W = 15,
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sks_pkg::ctl_type            prev_ctl,
   input  logic [KEY_W-1:0]            prev_carry_key,
   input  logic [sks_pkg::FLAG_W-1:0]  prev_carry_flags,
   input  logic [KEY_W-1:0]            prev_res_key,
   input  logic [sks_pkg::FLAG_W-1:0]  prev_res_flags,
   input  logic [CNT_W-1:0]            prev_res_ncur,
   input  logic [KEY_W-1:0]            probe_key,
   input  logic [sks_pkg::FLAG_W-1:0]  event_flags,
   input  logic [sks_pkg::FLAG_W-1:0]  event_mask,
   input  logic [CNT_W-1:0]            start_cursor,
   input  logic [CNT_W-1:0]            count,
   output sks_pkg::ctl_type            next_ctl,
   output logic [KEY_W-1:0]            next_carry_key,
   output logic [sks_pkg::FLAG_W-1:0]  next_carry_flags,
   output logic [KEY_W-1:0]            next_res_key,
   output logic [sks_pkg::FLAG_W-1:0]  next_res_flags,
   output logic [CNT_W-1:0]            next_res_ncur
);
   import sks_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_NEXT  = CNT_W'(INDEX + 1);

   logic [KEY_W-1:0]  key_ff, key_in;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   ctl_type           ctl_ff, ctl_in;
   logic [KEY_W-1:0]  carry_key_ff, carry_key_in;
   logic [FLAG_W-1:0] carry_flags_ff, carry_flags_in;
   logic [KEY_W-1:0]  res_key_ff, res_key_in;
   logic [FLAG_W-1:0] res_flags_ff, res_flags_in;
   logic [CNT_W-1:0]  res_ncur_ff, res_ncur_in;
   logic              occupied;
   logic [FLAG_W-1:0] masked;

   assign occupied = MY_INDEX < count;
   assign masked   = event_mask & flags_ff;

   always_comb begin
      ctl_in         = prev_ctl;
      carry_key_in   = prev_carry_key;
      carry_flags_in = prev_carry_flags;
      res_key_in     = prev_res_key;
      res_flags_in   = prev_res_flags;
      res_ncur_in    = prev_res_ncur;
      key_in         = key_ff;
      flags_in       = flags_ff;
      if (prev_ctl.active && !prev_ctl.resolved) begin
         case (prev_ctl.cmd)
            CMD_INSERT: begin
               if (prev_ctl.carry) begin
                  // shift: take the neighbor's entry, hand ours on
                  key_in         = prev_carry_key;
                  flags_in       = prev_carry_flags;
                  carry_key_in   = key_ff;
                  carry_flags_in = flags_ff;
                  ctl_in.carry   = occupied;
               end else if (!prev_ctl.placed) begin
                  if (!occupied || probe_key < key_ff) begin
                     if (prev_ctl.full) begin
                        ctl_in.resolved = 1'b1;
                        ctl_in.status   = ST_FULL;
                     end else begin
                        key_in         = probe_key;
                        flags_in       = '0;
                        ctl_in.placed  = 1'b1;
                        ctl_in.carry   = occupied;
                        carry_key_in   = key_ff;
                        carry_flags_in = flags_ff;
                     end
                  end else if (probe_key == key_ff) begin
                     ctl_in.resolved = 1'b1;
                     ctl_in.status   = ST_DUP;
                  end
               end
            end
            CMD_QUERY: begin
               if (occupied && probe_key == key_ff) begin
                  ctl_in.hit = 1'b1;
               end
            end
            CMD_SET_READY: begin
               if (occupied && probe_key == key_ff) begin
                  ctl_in.hit = 1'b1;
                  flags_in   = event_flags;
               end
            end
            CMD_SCAN: begin
               if (!prev_ctl.hit && occupied && MY_INDEX >= start_cursor &&
                   (!prev_ctl.use_mask || masked != '0)) begin
                  ctl_in.hit   = 1'b1;
                  res_key_in   = key_ff;
                  res_flags_in = prev_ctl.use_mask ? masked : flags_ff;
                  res_ncur_in  = MY_NEXT;
               end
            end
            CMD_CLEAR: begin
               flags_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         flags_ff <= '0;
      end else begin
         ctl_ff   <= ctl_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      carry_key_ff   <= carry_key_in;
      carry_flags_ff <= carry_flags_in;
      res_key_ff     <= res_key_in;
      res_flags_ff   <= res_flags_in;
      res_ncur_ff    <= res_ncur_in;
   end

   assign next_ctl         = ctl_ff;
   assign next_carry_key   = carry_key_ff;
   assign next_carry_flags = carry_flags_ff;
   assign next_res_key     = res_key_ff;
   assign next_res_flags   = res_flags_ff;
   assign next_res_ncur    = res_ncur_ff;

endmodule

[hdl/sorted_key_set_with_ready_scan_core.sv]
// Top level of the sorted key set with ready flags and cursor scan.
// A request passes the head token register, every cell's token stage and then the output register to rsp_valid.
// One request at a time: the next waits until the token, walking the cell row one cell a cycle, leaves it.
// A result that finds the output still stalled parks in a spare register; no new request
// enters until it leaves.
// Reset (synchronous): count, ready flags and all control clear; key slots keep their contents.
`timescale 1ns / 1ps

module sorted_key_set_with_ready_scan_core #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 16,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sks_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [KEY_BITS-1:0]        req_key,
   input  logic [sks_pkg::FLAG_W-1:0]        req_event_flags,
   input  logic [CNT_W-1:0]                  req_start_cursor,
   input  logic                              req_use_mask,
   input  logic [sks_pkg::FLAG_W-1:0]        req_event_mask,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sks_pkg::ST_W-1:0]          rsp_status,
   output logic                              rsp_found,
   output logic signed [KEY_BITS-1:0]        rsp_key_out,
   output logic [sks_pkg::FLAG_W-1:0]        rsp_flags_out,
   output logic [CNT_W-1:0]                  rsp_next_cursor,
   output logic [CNT_W-1:0]                  rsp_entry_count
);
   import sks_pkg::*;

   // Stored keys are never negative, so the sign bit is not kept.
   localparam int KW = KEY_BITS - 1;

   // Packed layout of one result word.
   localparam int CNT_LO = 0;
   localparam int CUR_LO = CNT_LO + CNT_W;
   localparam int FLG_LO = CUR_LO + CNT_W;
   localparam int KEY_LO = FLG_LO + FLAG_W;
   localparam int FND_LO = KEY_LO + KEY_BITS;
   localparam int ST_LO  = FND_LO + 1;
   localparam int RES_W  = ST_LO + ST_W;

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   // Request side and shared state.
   logic              req_accept;
   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   ctl_type           head_ctl_ff, head_ctl_in;

   // Operands are broadcast to every cell; only one request is in the row.
   logic [KW-1:0]     op_key_ff;
   logic [FLAG_W-1:0] op_flags_ff;
   logic [FLAG_W-1:0] op_mask_ff;
   logic [CNT_W-1:0]  op_cursor_ff;

   // Token links between neighboring cells; link 0 is the head, the last the tail.
   ctl_type           ctl_chain         [CAPACITY+1];
   logic [KW-1:0]     carry_key_chain   [CAPACITY+1];
   logic [FLAG_W-1:0] carry_flags_chain [CAPACITY+1];
   logic [KW-1:0]     res_key_chain     [CAPACITY+1];
   logic [FLAG_W-1:0] res_flags_chain   [CAPACITY+1];
   logic [CNT_W-1:0]  res_ncur_chain    [CAPACITY+1];

   // Tail decode.
   ctl_type           tail;
   logic              tail_valid;
   logic              inserted;
   logic              scan_hit;
   logic [ST_W-1:0]   res_status;
   logic              res_found;
   logic [KEY_BITS-1:0] res_key;
   logic [FLAG_W-1:0] res_flags;
   logic [CNT_W-1:0]  res_ncur;
   logic [CNT_W-1:0]  res_count;
   logic [RES_W-1:0]  res_word;

   // Response side: output register plus one parking register.
   logic              rsp_take;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]  rsp_word_ff, rsp_word_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [RES_W-1:0]  pend_word_ff, pend_word_in;

   // ------------------------------------------------------------------
   // Request intake: stall while a request walks the row or a result is parked.
   // ------------------------------------------------------------------
   assign req_stall  = busy_ff | pend_valid_ff;
   assign req_accept = req_valid & ~req_stall;

   // Build the head token; a negative key or an unused command is settled here.
   always_comb begin
      head_ctl_in = '0;
      if (req_accept) begin
         head_ctl_in.active   = 1'b1;
         head_ctl_in.cmd      = req_cmd;
         head_ctl_in.use_mask = req_use_mask;
         head_ctl_in.full     = (count_ff == CAP_COUNT);
         case (req_cmd)
            CMD_INSERT, CMD_QUERY, CMD_SET_READY: begin
               if (req_key[KEY_BITS-1]) begin
                  head_ctl_in.resolved = 1'b1;
                  head_ctl_in.status   = ST_INVALID;
               end
            end
            CMD_SCAN, CMD_CLEAR: begin
            end
            default: begin
               // unused codes change nothing and answer ok
               head_ctl_in.resolved = 1'b1;
               head_ctl_in.status   = ST_OK;
            end
         endcase
      end
   end

   // Hold operands for the whole walk.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_key_ff    <= req_key[KW-1:0];
         op_flags_ff  <= req_event_flags;
         op_mask_ff   <= req_event_mask;
         op_cursor_ff <= req_start_cursor;
      end
   end

   // ------------------------------------------------------------------
   // Cell row. Each cell acts on the token once as it passes and hands it on.
   // ------------------------------------------------------------------
   assign ctl_chain[0]         = head_ctl_ff;
   assign carry_key_chain[0]   = '0;
   assign carry_flags_chain[0] = '0;
   assign res_key_chain[0]     = '0;
   assign res_flags_chain[0]   = '0;
   assign res_ncur_chain[0]    = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sks_cell #(
         .KEY_W (KW),
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock            (clock),
         .reset            (reset),
         .prev_ctl         (ctl_chain[i]),
         .prev_carry_key   (carry_key_chain[i]),
         .prev_carry_flags (carry_flags_chain[i]),
         .prev_res_key     (res_key_chain[i]),
         .prev_res_flags   (res_flags_chain[i]),
         .prev_res_ncur    (res_ncur_chain[i]),
         .probe_key        (op_key_ff),
         .event_flags      (op_flags_ff),
         .event_mask       (op_mask_ff),
         .start_cursor     (op_cursor_ff),
         .count            (count_ff),
         .next_ctl         (ctl_chain[i+1]),
         .next_carry_key   (carry_key_chain[i+1]),
         .next_carry_flags (carry_flags_chain[i+1]),
         .next_res_key     (res_key_chain[i+1]),
         .next_res_flags   (res_flags_chain[i+1]),
         .next_res_ncur    (res_ncur_chain[i+1])
      );
   end

   // ------------------------------------------------------------------
   // Tail: turn the finished token into one result word.
   // ------------------------------------------------------------------
   assign tail       = ctl_chain[CAPACITY];
   assign tail_valid = tail.active;
   assign inserted   = tail.active & ~tail.resolved & (tail.cmd == CMD_INSERT) & tail.placed;
   assign scan_hit   = (tail.cmd == CMD_SCAN) & tail.hit;

   always_comb begin
      res_status = ST_OK;
      if (tail.resolved) begin
         res_status = tail.status;
      end else begin
         case (tail.cmd)
            CMD_INSERT: begin
               // never placed: key beyond every entry of a full set
               res_status = tail.placed ? ST_OK : ST_FULL;
            end
            CMD_QUERY, CMD_SET_READY, CMD_SCAN: begin
               res_status = tail.hit ? ST_OK : ST_NOTFOUND;
            end
            default: begin
               res_status = ST_OK;
            end
         endcase
      end
   end

   assign res_found = (~tail.resolved & (tail.cmd == CMD_QUERY) & tail.hit) | scan_hit;
   assign res_key   = scan_hit ? {1'b0, res_key_chain[CAPACITY]} : '1;
   assign res_flags = scan_hit ? res_flags_chain[CAPACITY] : '0;
   assign res_count = count_ff + CNT_W'(inserted);

   always_comb begin
      res_ncur = '0;
      if (tail.cmd == CMD_SCAN) begin
         res_ncur = tail.hit ? res_ncur_chain[CAPACITY] : count_ff;
      end
   end

   assign res_word = {res_status, res_found, res_key, res_flags, res_ncur, res_count};

   // ------------------------------------------------------------------
   // Response registers: load the output when free, else park the result.
   // ------------------------------------------------------------------
   assign rsp_take = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      if (tail_valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = res_word;
         end else begin
            pend_valid_in = 1'b1;
            pend_word_in  = res_word;
         end
      end else if (rsp_take) begin
         if (pend_valid_ff) begin
            rsp_word_in   = pend_word_ff;
            pend_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // Drop busy when the token leaves the row; advance count with the result.
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (tail_valid) begin
         busy_in = 1'b0;
      end
      if (tail_valid) begin
         count_in = res_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         head_ctl_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         count_ff      <= count_in;
         head_ctl_ff   <= head_ctl_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      pend_word_ff <= pend_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_word_ff[ST_LO +: ST_W];
   assign rsp_found       = rsp_word_ff[FND_LO];
   assign rsp_key_out     = rsp_word_ff[KEY_LO +: KEY_BITS];
   assign rsp_flags_out   = rsp_word_ff[FLG_LO +: FLAG_W];
   assign rsp_next_cursor = rsp_word_ff[CUR_LO +: CNT_W];
   assign rsp_entry_count = rsp_word_ff[CNT_LO +: CNT_W];

endmodule

[hdl/sks_checker.sv]
// Port-level checker of the sorted key set core and its bind.
`timescale 1ns / 1ps

`include "sorted_key_set_with_ready_scan_core_assert.svh"

module sks_checker #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 16,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [sks_pkg::ST_W-1:0]          rsp_status,
   input logic                              rsp_found,
   input logic signed [KEY_BITS-1:0]        rsp_key_out,
   input logic [sks_pkg::FLAG_W-1:0]        rsp_flags_out,
   input logic [CNT_W-1:0]                  rsp_next_cursor,
   input logic [CNT_W-1:0]                  rsp_entry_count
);
   import sks_pkg::*;

   `SKS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_key_out) && $stable(rsp_entry_count),
      "stalled response changed")
   `SKS_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall,
      "request taken while another is in flight")
   `SKS_ASSERT_IMP(a_count_range, clock, reset, rsp_valid,
      (rsp_entry_count <= CNT_W'(CAPACITY)) && (rsp_next_cursor <= rsp_entry_count),
      "count or cursor out of range")
   `SKS_ASSERT_IMP(a_found_ok, clock, reset, rsp_valid && rsp_found, rsp_status == ST_OK,
      "found with a failing status")
   `SKS_ASSERT_IMP(a_miss_fields, clock, reset, rsp_valid && !rsp_found,
      (rsp_key_out == {KEY_BITS{1'b1}}) && (rsp_flags_out == '0),
      "miss carries key or flags")

endmodule

bind sorted_key_set_with_ready_scan_core sks_checker #(
   .CAPACITY (CAPACITY),
   .KEY_BITS (KEY_BITS)
) u_sks_checker (.*);

[tb/sks_checker.sv]
// Checker for the sorted key set core: predicts every result and compares it with the one seen.
`timescale 1ns / 1ps

module sks_scoreboard #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 16,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [sks_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [KEY_BITS-1:0]        req_key,
   input  logic [sks_pkg::FLAG_W-1:0]        req_event_flags,
   input  logic [CNT_W-1:0]                  req_start_cursor,
   input  logic                              req_use_mask,
   input  logic [sks_pkg::FLAG_W-1:0]        req_event_mask,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [sks_pkg::ST_W-1:0]          rsp_status,
   input  logic                              rsp_found,
   input  logic signed [KEY_BITS-1:0]        rsp_key_out,
   input  logic [sks_pkg::FLAG_W-1:0]        rsp_flags_out,
   input  logic [CNT_W-1:0]                  rsp_next_cursor,
   input  logic [CNT_W-1:0]                  rsp_entry_count,
   output int                                mismatch_count,
   output int                                answers_waiting,
   output int                                results_checked
);
   import sks_pkg::*;

   typedef struct {
      logic [ST_W-1:0]     status;
      logic                found;
      logic [KEY_BITS-1:0] key_out;
      logic [FLAG_W-1:0]   flags_out;
      logic [CNT_W-1:0]    next_cursor;
      logic [CNT_W-1:0]    entry_count;
   } answer_type;

   // Shadow copy of the set: keys kept ascending, flags ride along with them.
   logic [KEY_BITS-2:0] member_key [CAPACITY];
   logic [FLAG_W-1:0]   member_flags [CAPACITY];
   int                  member_count;

   answer_type expected_answers[$];

   task automatic report_mismatch(input string what);
      $display("sks_scoreboard: %s", what);
      mismatch_count++;
   endtask

   // Lower bound: first index whose key is not below k.
   function automatic int lower_bound(input logic [KEY_BITS-2:0] k);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = member_count;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (member_key[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   // Apply one request to the shadow set and return the answer it earns.
   function automatic answer_type execute_command(
      input logic [CMD_W-1:0]    cmd,
      input logic [KEY_BITS-1:0] key,
      input logic [FLAG_W-1:0]   eflags,
      input logic [CNT_W-1:0]    cursor,
      input logic                use_mask,
      input logic [FLAG_W-1:0]   emask
   );
      answer_type        a;
      logic              neg;
      int                pos;
      logic              hit;
      int                i;
      logic [FLAG_W-1:0] f;
      a.status      = ST_OK;
      a.found       = 1'b0;
      a.key_out     = '1;
      a.flags_out   = '0;
      a.next_cursor = '0;
      neg = key[KEY_BITS-1];
      pos = lower_bound(key[KEY_BITS-2:0]);
      hit = !neg && pos < member_count && member_key[pos] == key[KEY_BITS-2:0];
      case (cmd)
         CMD_INSERT: begin
            if (neg) a.status = ST_INVALID;
            else if (hit) a.status = ST_DUP;
            else if (member_count >= CAPACITY) a.status = ST_FULL;
            else begin
               for (i = member_count; i > pos; i--) begin
                  member_key[i]   = member_key[i-1];
                  member_flags[i] = member_flags[i-1];
               end
               member_key[pos]   = key[KEY_BITS-2:0];
               member_flags[pos] = '0;
               member_count++;
            end
         end
         CMD_QUERY: begin
            if (neg) a.status = ST_INVALID;
            else if (hit) a.found = 1'b1;
            else a.status = ST_NOTFOUND;
         end
         CMD_SET_READY: begin
            if (neg) a.status = ST_INVALID;
            else if (hit) member_flags[pos] = eflags;
            else a.status = ST_NOTFOUND;
         end
         CMD_SCAN: begin
            a.status      = ST_NOTFOUND;
            a.next_cursor = CNT_W'(member_count);
            for (i = cursor; i < member_count && !a.found; i++) begin
               f = use_mask ? (emask & member_flags[i]) : member_flags[i];
               if (!use_mask || f != '0) begin
                  a.status      = ST_OK;
                  a.found       = 1'b1;
                  a.key_out     = {1'b0, member_key[i]};
                  a.flags_out   = f;
                  a.next_cursor = CNT_W'(i + 1);
               end
            end
         end
         CMD_CLEAR: begin
            for (i = 0; i < CAPACITY; i++) member_flags[i] = '0;
         end
         default: ;
      endcase
      a.entry_count = CNT_W'(member_count);
      return a;
   endfunction

   // Results first: a result leaving at this edge always belongs to an earlier request.
   always @(posedge clock) begin
      answer_type want;
      int         i;
      if (reset) begin
         member_count = 0;
         for (i = 0; i < CAPACITY; i++) member_flags[i] = '0;
         expected_answers.delete();
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no request waiting",
                                         results_checked));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                            results_checked, want.status, rsp_status));
               if (rsp_found !== want.found)
                  report_mismatch($sformatf("result %0d found: expected %0b, got %0b",
                                            results_checked, want.found, rsp_found));
               if (rsp_key_out !== want.key_out)
                  report_mismatch($sformatf("result %0d key_out: expected %0h, got %0h",
                                            results_checked, want.key_out, rsp_key_out));
               if (rsp_flags_out !== want.flags_out)
                  report_mismatch($sformatf("result %0d flags_out: expected %0h, got %0h",
                                            results_checked, want.flags_out, rsp_flags_out));
               if (rsp_next_cursor !== want.next_cursor)
                  report_mismatch($sformatf("result %0d next_cursor: expected %0d, got %0d",
                                            results_checked, want.next_cursor,
                                            rsp_next_cursor));
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch($sformatf("result %0d entry_count: expected %0d, got %0d",
                                            results_checked, want.entry_count,
                                            rsp_entry_count));
            end
            results_checked++;
         end
         if (req_valid && !req_stall)
            expected_answers.push_back(execute_command(req_cmd, req_key, req_event_flags,
                                                       req_start_cursor, req_use_mask,
                                                       req_event_mask));
      end
      answers_waiting = expected_answers.size();
   end

endmodule

[tb/tb_top.sv]
// Testbench top for the sorted key set core: stimulus, stall patterns and the verdict.
`timescale 1ns / 1ps

module tb_top;
   import sks_pkg::*;

   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Roughly 1550 requests in all, directed ones included.
   localparam int TOTAL_REQUESTS = 1550;
   // Bound on the whole run: with worst-case sender gaps and receiver stalls on every request
   // included, this is several times the slowest run.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Long receiver hold-off: well past the block latency so the parked result blocks input.
   localparam int HOLD_OFF_CYCLES = 300;

   // Command codes the block treats as no operation.
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   localparam logic [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
   localparam logic [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
   localparam logic [KEY_BITS-1:0] KEY_NEG_ONE = '1;
   localparam logic [FLAG_W-1:0]   FLAGS_ALL = '1;
   localparam logic [CNT_W-1:0]    CURSOR_END = CNT_W'(CAPACITY);

   typedef enum {STALL_NEVER, STALL_RANDOM, STALL_RUNS} stall_mode_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [CMD_W-1:0]           req_cmd;
   logic signed [KEY_BITS-1:0] req_key;
   logic [FLAG_W-1:0]          req_event_flags;
   logic [CNT_W-1:0]           req_start_cursor;
   logic                       req_use_mask;
   logic [FLAG_W-1:0]          req_event_mask;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [ST_W-1:0]            rsp_status;
   logic                       rsp_found;
   logic signed [KEY_BITS-1:0] rsp_key_out;
   logic [FLAG_W-1:0]          rsp_flags_out;
   logic [CNT_W-1:0]           rsp_next_cursor;
   logic [CNT_W-1:0]           rsp_entry_count;

   int mismatch_count;
   int answers_waiting;
   int results_checked;

   // Stimulus bookkeeping.
   int                  requests_sent = 0;
   int                  cmd_sent [8];
   logic [KEY_BITS-2:0] known_keys[$];     // every non-negative key ever offered for insert
   int                  gap_max = 0;       // longest sender gap in the current phase
   int                  burst_left = 1;
   bit                  hold_off_asked = 1'b0;
   int                  hold_offs_done = 0;
   int                  cycles_run = 0;

   always #1 clock = ~clock;

   sorted_key_set_with_ready_scan_core #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_event_flags  (req_event_flags),
      .req_start_cursor (req_start_cursor),
      .req_use_mask     (req_use_mask),
      .req_event_mask   (req_event_mask),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_key_out      (rsp_key_out),
      .rsp_flags_out    (rsp_flags_out),
      .rsp_next_cursor  (rsp_next_cursor),
      .rsp_entry_count  (rsp_entry_count)
   );

   sks_scoreboard #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_event_flags  (req_event_flags),
      .req_start_cursor (req_start_cursor),
      .req_use_mask     (req_use_mask),
      .req_event_mask   (req_event_mask),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_key_out      (rsp_key_out),
      .rsp_flags_out    (rsp_flags_out),
      .rsp_next_cursor  (rsp_next_cursor),
      .rsp_entry_count  (rsp_entry_count),
      .mismatch_count   (mismatch_count),
      .answers_waiting  (answers_waiting),
      .results_checked  (results_checked)
   );

   // Watchdog: end the run if it hangs anywhere, drain waits included.
   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles", CYCLE_LIMIT);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Receiver: switch between no stall, random stall and long stall runs; a hold-off
   // request from the stimulus side overrides all of it until that hold-off runs out.
   initial begin : receiver
      stall_mode_type mode;
      int             mode_left;
      int             run_left;
      int             hold_left;
      bit             stalled;
      mode      = STALL_NEVER;
      mode_left = 0;
      run_left  = 0;
      hold_left = 0;
      stalled   = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            stalled = 1'b1;
         end else if (hold_off_asked) begin
            hold_off_asked = 1'b0;
            hold_left      = HOLD_OFF_CYCLES - 1;
            stalled        = 1'b1;
            hold_offs_done++;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(100, 800);
            end
            mode_left--;
            case (mode)
               STALL_NEVER:  stalled = 1'b0;
               STALL_RANDOM: stalled = ($urandom_range(0, 2) == 0);
               default: begin
                  if (run_left == 0) begin
                     stalled  = !stalled;
                     run_left = stalled ? $urandom_range(1, 70) : $urandom_range(1, 40);
                  end else begin
                     run_left--;
                  end
               end
            endcase
         end
         rsp_stall <= stalled;
      end
   end

   // Drop valid for a number of cycles; with drain set, also hold until every result is back.
   task automatic sender_idle(input int cycles, input bit drain);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
      if (drain) begin
         while (answers_waiting != 0) @(posedge clock);
      end
   endtask

   // Burst pacing: after a burst of random length, idle a random gap (none when gap_max is 0).
   task automatic pace_sender();
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         if (gap_max > 0) sender_idle($urandom_range(1, gap_max), 1'b0);
      end
   endtask

   // Offer one request and hold it until accepted. Called right after a rising edge.
   task automatic send_request(
      input logic [CMD_W-1:0]    cmd,
      input logic [KEY_BITS-1:0] key,
      input logic [FLAG_W-1:0]   eflags,
      input logic [CNT_W-1:0]    cursor,
      input logic                use_mask,
      input logic [FLAG_W-1:0]   emask
   );
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_key          <= key;
      req_event_flags  <= eflags;
      req_start_cursor <= cursor;
      req_use_mask     <= use_mask;
      req_event_mask   <= emask;
      do @(posedge clock); while (req_stall !== 1'b0);
      requests_sent++;
      cmd_sent[cmd]++;
      if (cmd == CMD_INSERT && !key[KEY_BITS-1]) known_keys.push_back(key[KEY_BITS-2:0]);
      pace_sender();
   endtask

   // Random cursor anywhere from zero to CAPACITY, one past the last slot.
   function automatic logic [CNT_W-1:0] pick_cursor();
      return CNT_W'($urandom_range(0, CAPACITY));
   endfunction

   // Random mask-enable bit.
   function automatic logic pick_bit();
      return 1'($urandom);
   endfunction

   // Key choice: pool_pct percent from keys already offered (hits and duplicates),
   // then the two extremes, then negatives, the rest fresh non-negative keys.
   function automatic logic [KEY_BITS-1:0] pick_key(input int pool_pct);
      int                  r;
      logic [KEY_BITS-1:0] k;
      r = $urandom_range(0, 99);
      k = KEY_BITS'($urandom);
      if (r < pool_pct && known_keys.size() > 0)
         return {1'b0, known_keys[$urandom_range(0, known_keys.size() - 1)]};
      if (r < pool_pct + 10) return $urandom_range(0, 1) ? KEY_MAX : '0;
      k[KEY_BITS-1] = (r < pool_pct + 25);
      return k;
   endfunction

   // Flag words: zero, all ones, a single bit, or anything.
   function automatic logic [FLAG_W-1:0] pick_flags();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return '0;
      if (r < 3) return FLAGS_ALL;
      if (r < 5) return FLAG_W'(1 << $urandom_range(0, FLAG_W - 1));
      return FLAG_W'($urandom);
   endfunction

   // Poll-style round: mark a few keys ready, walk the set with a filtered scan from
   // cursor zero with forward jumps, then often clear all flags.
   task automatic run_poll_round();
      int                n;
      int                cursor;
      logic [FLAG_W-1:0] mask;
      n = $urandom_range(2, 6);
      repeat (n) send_request(CMD_SET_READY, pick_key(75), FLAG_W'($urandom_range(1, 65535)),
                              pick_cursor(), pick_bit(), pick_flags());
      mask   = ($urandom_range(0, 3) == 0) ? FLAGS_ALL : pick_flags();
      cursor = 0;
      for (n = 0; n < 8 && cursor <= CAPACITY; n++) begin
         send_request(CMD_SCAN, pick_key(50), pick_flags(), CNT_W'(cursor), 1'b1, mask);
         cursor += $urandom_range(1, 12);
      end
      if ($urandom_range(0, 1) == 0)
         send_request(CMD_CLEAR, pick_key(50), pick_flags(), pick_cursor(),
                      pick_bit(), pick_flags());
   endtask

   initial begin : stimulus
      int                phase;
      int                phase_len;
      int                j;
      int                roll;
      int                pick;
      logic [CNT_W-1:0]  cursor;
      for (j = 0; j < 8; j++) cmd_sent[j] = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= CMD_INSERT;
      req_key          <= '0;
      req_event_flags  <= '0;
      req_start_cursor <= '0;
      req_use_mask     <= 1'b0;
      req_event_mask   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty set, extremes of the key range, invalid and duplicate keys,
      // hits and misses, flag writes, every scan outcome, spare codes and clear.
      gap_max = 3;
      send_request(CMD_SCAN,      '0,          '0,        '0,         1'b0, '0);
      send_request(CMD_SCAN,      '0,          '0,        CURSOR_END, 1'b1, FLAGS_ALL);
      send_request(CMD_QUERY,     '0,          '0,        '0,         1'b0, '0);
      send_request(CMD_INSERT,    '0,          '0,        '0,         1'b0, '0);
      send_request(CMD_INSERT,    KEY_MAX,     FLAGS_ALL, '0,         1'b0, '0);
      send_request(CMD_INSERT,    KEY_MIN,     '0,        '0,         1'b0, '0);
      send_request(CMD_INSERT,    KEY_NEG_ONE, '0,        '0,         1'b0, '0);
      send_request(CMD_INSERT,    '0,          '0,        '0,         1'b0, '0);
      send_request(CMD_INSERT,    16'h2aaa,    '0,        '0,         1'b0, '0);
      send_request(CMD_QUERY,     KEY_MAX,     '0,        '0,         1'b0, '0);
      send_request(CMD_QUERY,     KEY_NEG_ONE, '0,        '0,         1'b0, '0);
      send_request(CMD_QUERY,     16'd5,       '0,        '0,         1'b0, '0);
      send_request(CMD_SET_READY, KEY_MAX,     FLAGS_ALL, '0,         1'b0, '0);
      send_request(CMD_SET_READY, '0,          16'h0001,  '0,         1'b0, '0);
      send_request(CMD_SET_READY, 16'h8001,    16'h5555,  '0,         1'b0, '0);
      send_request(CMD_SET_READY, 16'h1234,    16'haaaa,  '0,         1'b0, '0);
      send_request(CMD_SCAN,      '0,          '0,        '0,         1'b0, '0);
      send_request(CMD_SCAN,      '0,          '0,        '0,         1'b1, 16'h8000);
      send_request(CMD_SCAN,      '0,          '0,        '0,         1'b1, '0);
      send_request(CMD_SCAN,      '0,          '0,        7'd1,       1'b0, '0);
      send_request(CMD_SCAN,      '0,          '0,        7'd3,       1'b0, '0);
      send_request(CMD_SPARE_FIRST, KEY_MAX,   FLAGS_ALL, CURSOR_END, 1'b1, FLAGS_ALL);
      send_request(CMD_SPARE_LAST,  '0,        '0,        '0,         1'b0, '0);
      send_request(CMD_CLEAR,     '0,          '0,        '0,         1'b0, '0);
      send_request(CMD_SCAN,      '0,          '0,        '0,         1'b1, FLAGS_ALL);
      sender_idle(1, 1'b1);

      // Random part in phases, each with its own sender gap profile. The set only
      // grows, so early phases see small sets and later ones a full set.
      phase = 0;
      while (requests_sent < TOTAL_REQUESTS) begin
         phase_len = $urandom_range(60, 160);
         case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 8;
            default: gap_max = 70;
         endcase
         // Hold off the receiver while the sender keeps offering back to back.
         if (phase == 1 || $urandom_range(0, 6) == 0) begin
            hold_off_asked = 1'b1;
            gap_max        = 0;
         end
         for (j = 0; j < phase_len && requests_sent < TOTAL_REQUESTS; j++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               run_poll_round();
            end else if (roll < 26) begin
               send_request(CMD_INSERT, pick_key(30), pick_flags(),
                            pick_cursor(), pick_bit(), pick_flags());
            end else if (roll < 44) begin
               send_request(CMD_QUERY, pick_key(60), pick_flags(),
                            pick_cursor(), pick_bit(), pick_flags());
            end else if (roll < 60) begin
               send_request(CMD_SET_READY, pick_key(65), pick_flags(),
                            pick_cursor(), pick_bit(), pick_flags());
            end else if (roll < 93) begin
               pick = $urandom_range(0, 9);
               if (pick < 5) cursor = CNT_W'($urandom_range(0, 8));
               else if (pick < 9) cursor = pick_cursor();
               else cursor = CURSOR_END;
               send_request(CMD_SCAN, pick_key(50), pick_flags(), cursor, pick_bit(),
                            pick_flags());
            end else if (roll < 96) begin
               send_request(CMD_CLEAR, pick_key(50), pick_flags(),
                            pick_cursor(), pick_bit(), pick_flags());
            end else begin
               send_request(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                            pick_key(50), pick_flags(), pick_cursor(), pick_bit(),
                            pick_flags());
            end
         end
         // Pause the sender now and then until the block has answered everything.
         if (phase == 2 || $urandom_range(0, 1) == 0) sender_idle(1, 1'b1);
         phase++;
      end

      // Drain, then give the block a full latency more to show any stray result.
      sender_idle(1, 1'b1);
      repeat (CAPACITY + 8) @(posedge clock);

      $display("tb_top: %0d requests: %0d inserts, %0d queries, %0d flag writes,",
               requests_sent, cmd_sent[CMD_INSERT], cmd_sent[CMD_QUERY],
               cmd_sent[CMD_SET_READY]);
      $display("tb_top: %0d scans, %0d clears, %0d results checked, %0d hold-offs, %0d mismatches",
               cmd_sent[CMD_SCAN], cmd_sent[CMD_CLEAR], results_checked, hold_offs_done,
               mismatch_count);
      if (mismatch_count == 0 && answers_waiting == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
